FILE: sv/mi4_pkg.sv
// Package with shared widths for the 4x4 matrix inverse unit.
package mi4_pkg;
  localparam int ELEM_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF = 8;
  localparam int OUT_BITS = 32;
  localparam int QUO_BITS = 34;
endpackage

FILE: sv/mi4_divider.sv
// Restoring divider that forms one quotient bit per cycle.
module mi4_divider import mi4_pkg::*; #(
  parameter int NUM_BITS = 64,
  parameter int DEN_BITS = 56
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [NUM_BITS-1:0] num,
  input  logic [DEN_BITS-1:0] den,
  output logic                done,
  output logic [NUM_BITS-1:0] quo
);
  localparam int CW = $clog2(NUM_BITS + 1);
  logic [NUM_BITS-1:0] q_r, q_nxt;
  logic [DEN_BITS:0]   rem_r, rem_nxt;
  logic [DEN_BITS-1:0] den_r, den_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                act_r, act_nxt, done_r, done_nxt;
  logic [DEN_BITS:0]   trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    act_nxt = act_r; done_nxt = 1'b0;
    trial = {rem_r[DEN_BITS-1:0], q_r[NUM_BITS-1]};
    if (go) begin
      q_nxt = num; rem_nxt = '0; den_nxt = den;
      cnt_nxt = CW'(NUM_BITS); act_nxt = 1'b1;
    end else if (act_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NUM_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NUM_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        act_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      act_r <= act_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

  a_done_after_act: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(act_r)) else $error("done without active divide");
  a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    act_r && !done_r |-> cnt_r != '0) else $error("divider count underflow");
endmodule

FILE: sv/matrix_inverse_4x4_unit.sv
// Top level of the 4x4 matrix inverse unit: element load, cofactor sequencer and output.
// Loading takes one item per cycle with start high while busy is low; the sixteenth item starts a run.
// A run forms 16 cofactors in the sequencer, sums the determinant from four
// products, then makes 16 divides on the shared divider; a singular matrix skips
// the divides. One result strobes per divide, or per element of a singular matrix;
// the receiver cannot stall. Synchronous active-low reset clears the load count
// and sequencer; stores hold garbage until written.
module matrix_inverse_4x4_unit import mi4_pkg::*; #(
  parameter int ELEM_BITS = ELEM_BITS_DEF,
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [11:0] in_elem_value,
  output logic               out_valid,
  output logic signed [31:0] out_inv_value,
  output logic               out_singular,
  output logic               out_last_of_run
);
  // Widths of the products: a cofactor is a sum of six triple products,
  // the determinant a sum of four products of element and cofactor.
  localparam int COF_BITS = 3 * ELEM_BITS + 4;
  localparam int DET_BITS = 4 * ELEM_BITS + 6;
  localparam int SH       = FRAC_BITS + 16;
  localparam int NUM_BITS = COF_BITS + SH;

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_COF  = 3'd1;
  localparam logic [2:0] S_DET  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_WAIT = 3'd4;

  logic [2:0] st_r, st_nxt;
  logic [3:0] ld_r, ld_nxt;
  logic [3:0] k_r, k_nxt;     // cofactor or result index
  logic [4:0] t_r, t_nxt;     // term step within one cofactor
  logic signed [ELEM_BITS-1:0] mat_r [16];
  logic signed [COF_BITS-1:0]  cof_r [16];
  logic signed [COF_BITS-1:0]  acc_r, acc_nxt;
  logic signed [DET_BITS-1:0]  det_r, det_nxt;
  logic signed [2*ELEM_BITS-1:0] pp_r;  // registered partial product

  // Each of the six permutation terms of a 3x3 determinant takes two steps:
  // form a*b into pp_r, then accumulate pp_r*c with its sign.
  logic [1:0] rows [3];
  logic [1:0] cols [3];
  logic [1:0] ci, cj;
  logic [2:0] term;
  logic       phase;
  logic [1:0] p0, p1, p2;
  logic       tneg;
  logic signed [ELEM_BITS-1:0] ea, eb, ec;
  logic signed [3*ELEM_BITS-1:0] trip;

  assign ci = k_r[3:2];
  assign cj = k_r[1:0];
  assign term  = t_r[3:1];
  assign phase = t_r[0];

  always_comb begin
    for (int n = 0; n < 3; n++) begin
      rows[n] = (2'(n) >= ci) ? 2'(n + 1) : 2'(n);
      cols[n] = (2'(n) >= cj) ? 2'(n + 1) : 2'(n);
    end
    case (term)
      3'd0: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; tneg = 1'b0; end
      3'd1: begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; tneg = 1'b0; end
      3'd2: begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; tneg = 1'b0; end
      3'd3: begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; tneg = 1'b1; end
      3'd4: begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; tneg = 1'b1; end
      3'd5: begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; tneg = 1'b1; end
      default: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; tneg = 1'b0; end
    endcase
    if (ci[0] ^ cj[0]) tneg = ~tneg;
    ea = mat_r[{rows[0], cols[p0]}];
    eb = mat_r[{rows[1], cols[p1]}];
    ec = mat_r[{rows[2], cols[p2]}];
    trip = pp_r * ec;
  end

  // Determinant term: first-row element times its cofactor, at full width.
  logic signed [DET_BITS-1:0] dprod;

  assign dprod = mat_r[{2'd0, k_r[1:0]}] * cof_r[{2'd0, k_r[1:0]}];

  // Divider operands for result k: transposed cofactor over determinant.
  logic signed [COF_BITS-1:0] dcof;
  logic [COF_BITS-1:0] dmag;
  logic [DET_BITS-1:0] detmag;
  logic neg_r, dgo, ddone, sing;
  logic [NUM_BITS-1:0] quo;
  logic signed [31:0] res;

  assign dcof   = cof_r[{k_r[1:0], k_r[3:2]}];
  assign dmag   = dcof[COF_BITS-1] ? COF_BITS'(-dcof) : COF_BITS'(dcof);
  assign detmag = det_r[DET_BITS-1] ? DET_BITS'(-det_r) : DET_BITS'(det_r);
  assign sing   = (det_r == '0);
  assign dgo    = (st_r == S_DIV) && !sing;

  mi4_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DET_BITS)) u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo),
    .num({dmag, SH'(0)}), .den(detmag), .done(ddone), .quo(quo)
  );

  always_comb begin
    if (neg_r) begin
      if (quo > NUM_BITS'(33'h80000000)) res = 32'sh80000000;
      else res = 32'(-quo);
    end else begin
      if (quo > NUM_BITS'(32'h7FFFFFFF)) res = 32'sh7FFFFFFF;
      else res = 32'(quo);
    end
  end

  always_comb begin
    st_nxt = st_r; ld_nxt = ld_r; k_nxt = k_r; t_nxt = t_r;
    acc_nxt = acc_r; det_nxt = det_r;
    case (st_r)
      S_LOAD: begin
        if (start) begin
          ld_nxt = ld_r + 1'b1;
          if (ld_r == 4'd15) begin
            st_nxt = S_COF; k_nxt = '0; t_nxt = '0; acc_nxt = '0;
          end
        end
      end
      S_COF: begin
        if (phase) acc_nxt = tneg ? acc_r - COF_BITS'(trip) : acc_r + COF_BITS'(trip);
        t_nxt = t_r + 1'b1;
        if (t_r == 5'd11) begin
          t_nxt = '0; acc_nxt = '0; k_nxt = k_r + 1'b1;
          if (k_r == 4'd15) begin
            st_nxt = S_DET; k_nxt = '0; det_nxt = '0;
          end
        end
      end
      S_DET: begin
        det_nxt = det_r + dprod;
        k_nxt = k_r + 1'b1;
        if (k_r == 4'd3) begin
          st_nxt = S_DIV; k_nxt = '0;
        end
      end
      S_DIV: begin
        if (sing) begin
          k_nxt = k_r + 1'b1;
          if (k_r == 4'd15) st_nxt = S_LOAD;
        end else st_nxt = S_WAIT;
      end
      S_WAIT: begin
        if (ddone) begin
          k_nxt = k_r + 1'b1;
          st_nxt = (k_r == 4'd15) ? S_LOAD : S_DIV;
        end
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; ld_r <= '0; k_r <= '0; t_r <= '0;
      out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt; ld_r <= ld_nxt; k_r <= k_nxt; t_r <= t_nxt;
      out_valid <= (st_r == S_DIV && sing) || (st_r == S_WAIT && ddone);
    end
    acc_r <= acc_nxt;
    det_r <= det_nxt;
    if (st_r == S_LOAD && start) mat_r[ld_r] <= in_elem_value[ELEM_BITS-1:0];
    if (st_r == S_COF && !phase) pp_r <= ea * eb;
    if (st_r == S_COF && t_r == 5'd11)
      cof_r[k_r] <= tneg ? acc_r - COF_BITS'(trip) : acc_r + COF_BITS'(trip);
    if (dgo) neg_r <= dcof[COF_BITS-1] ^ det_r[DET_BITS-1];
    out_inv_value   <= (st_r == S_DIV && sing) ? 32'sd0 : res;
    out_singular    <= (st_r == S_DIV && sing);
    out_last_of_run <= (k_r == 4'd15);
  end

  assign busy = (st_r != S_LOAD);

  a_idle_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_of_run |-> !busy) else $error("last result without return to load");
  a_run_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(ld_r) == 4'd15 && $past(start)) else $error("run began early");
endmodule

FILE: verif/matrix_inverse_4x4_unit_tb.sv
`timescale 1ns / 100ps
// Testbench for the 4x4 fixed-point matrix inverse unit, checked against its own predictor.
module matrix_inverse_4x4_unit_tb;

  // One expected inverse element: value, singular flag, end-of-run flag.
  typedef struct packed {
    logic signed [31:0] inv_value;
    logic               singular;
    logic               last_of_run;
  } inv_elem_t;

  // Scoreboard: holds the loaded matrix, predicts the sixteen inverse elements
  // once the last element arrives, and compares each strobed result in order.
  class inverse_scoreboard;
    logic signed [63:0] elems[16];
    int unsigned        load_idx;
    inv_elem_t          pending[$];
    int unsigned        errors;

    function new();
      load_idx = 0;
      errors = 0;
    endfunction

    // Determinant of the 3x3 minor with row r and column c removed.
    function automatic logic signed [63:0] minor_det(int r, int c);
      logic signed [63:0] a[3][3];
      int i;
      int j;
      i = 0;
      for (int k = 0; k < 4; k++) begin
        if (k != r) begin
          j = 0;
          for (int l = 0; l < 4; l++) begin
            if (l != c) begin
              a[i][j] = elems[k*4+l];
              j++;
            end
          end
          i++;
        end
      end
      return a[0][0] * (a[1][1]*a[2][2] - a[1][2]*a[2][1])
           - a[0][1] * (a[1][0]*a[2][2] - a[1][2]*a[2][0])
           + a[0][2] * (a[1][0]*a[2][1] - a[1][1]*a[2][0]);
    endfunction

    // Quotient cof * 2^24 / det, truncated toward zero and saturated to 32 bits.
    function automatic logic signed [31:0] q16_quotient(logic signed [63:0] cof,
                                                       logic signed [63:0] det);
      logic        neg;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      neg = (cof < 0) != (det < 0);
      num = (cof < 0 ? -cof : cof) << 24;
      den = det < 0 ? -det : det;
      q = num / den;
      if (neg) begin
        if (q > 64'h8000_0000) q = 64'h8000_0000;
        return -q[31:0];
      end
      if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
      return q[31:0];
    endfunction

    function void note_element(logic signed [11:0] v);
      logic signed [63:0] cof[16];
      logic signed [63:0] det;
      inv_elem_t          e;
      elems[load_idx] = v;
      if (load_idx != 15) begin
        load_idx++;
        return;
      end
      load_idx = 0;
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          cof[i*4+j] = ((i + j) % 2) ? -minor_det(i, j) : minor_det(i, j);
      det = 0;
      for (int j = 0; j < 4; j++) det += elems[j] * cof[j];
      for (int k = 0; k < 16; k++) begin
        e.inv_value = (det != 0) ? q16_quotient(cof[(k%4)*4 + k/4], det) : 32'sd0;
        e.singular = (det == 0);
        e.last_of_run = (k == 15);
        pending.push_back(e);
      end
    endfunction

    function void check_result(logic signed [31:0] v, logic s, logic l);
      inv_elem_t e;
      if (pending.size() == 0) begin
        $error("unexpected result inv_value=%0d", v);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (v !== e.inv_value) begin
        $error("inv_value expected %0d actual %0d", e.inv_value, v);
        errors++;
      end
      if (s !== e.singular) begin
        $error("singular expected %0b actual %0b", e.singular, s);
        errors++;
      end
      if (l !== e.last_of_run) begin
        $error("last_of_run expected %0b actual %0b", e.last_of_run, l);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [11:0] in_elem_value;
  logic               out_valid;
  logic signed [31:0] out_inv_value;
  logic               out_singular;
  logic               out_last_of_run;

  inverse_scoreboard scb;
  logic              gaps_on;

  matrix_inverse_4x4_unit u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_elem_value(in_elem_value), .out_valid(out_valid),
    .out_inv_value(out_inv_value), .out_singular(out_singular),
    .out_last_of_run(out_last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Results cannot be stalled, so every strobe is checked at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_valid) scb.check_result(out_inv_value, out_singular, out_last_of_run);
  end

  // Offers one element and holds it until an edge with busy low takes it.
  // The optional random gap before it lands on any phase of a run.
  // Start stays high on return; the next call or the caller drops it.
  task automatic send_element(logic signed [11:0] v);
    int gap;
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_elem_value <= v;
    do @(posedge clk); while (busy);
    scb.note_element(v);
    @(negedge clk);
  endtask

  // Sends a whole matrix; mode picks the kind of content.
  task automatic send_matrix(int mode);
    logic signed [11:0] v;
    for (int k = 0; k < 16; k++) begin
      case (mode)
        0: v = 12'($urandom);
        1: v = $urandom_range(0, 1) ? 12'sh7FF : 12'sh800;
        // Near-identity scaled matrices keep determinants comfortable.
        2: v = (k % 5 == 0) ? 12'(256 + $urandom_range(0, 600)) : 12'($urandom_range(0, 60)) - 12'sd30;
        // Small elements give tiny determinants and saturated quotients.
        default: v = 12'($urandom_range(0, 6)) - 12'sd3;
      endcase
      send_element(v);
    end
  endtask

  task automatic send_fixed(int which);
    for (int k = 0; k < 16; k++) begin
      case (which)
        0: send_element((k % 5 == 0) ? 12'sd256 : 12'sd0);     // identity
        1: send_element(12'sd0);                               // all zero, singular
        2: send_element((k % 5 == 0) ? 12'sd1 : 12'sd0);       // tiny diagonal, large quotients
        3: send_element((k % 5 == 0) ? ((k == 0) ? -12'sd1 : 12'sd1) : 12'sd0);
        default: send_element((k % 5 == 0) ? 12'sh800 : 12'sd0);
      endcase
    end
  endtask

  initial begin
    scb = new();
    gaps_on = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_elem_value = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed matrices: identity, zero, tiny diagonals of both signs, most negative.
    for (int w = 0; w < 5; w++) send_fixed(w);
    send_matrix(1);

    // Random matrices with idle gaps, then a final stretch with none.
    gaps_on = 1'b1;
    for (int m = 0; m < 10; m++) send_matrix($urandom_range(0, 3));
    gaps_on = 1'b0;
    for (int m = 0; m < 4; m++) send_matrix($urandom_range(0, 3));
    start <= 1'b0;

    while (scb.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (scb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog timeout; all 20 runs with gaps fit well inside this.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
